/* hdl/szpw_pkg.sv */
// Shared constants, codes and types of the spherical zone protection weight unit.
// Used by szpw_seq_unit, spherical_zone_protection_weight_unit and the testbench; depends on nothing.
package szpw_pkg;

    localparam int MAX_ZONES = 32;
    localparam int ZONE_AW   = $clog2(MAX_ZONES);
    localparam int CNT_W     = $clog2(MAX_ZONES + 1);
    localparam int ENTRY_W   = 160;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_Z   = 3'd2;
    localparam logic [2:0] REG_RADIUS     = 3'd3;
    localparam logic [2:0] REG_ENTRIES    = 3'd4;
    localparam logic [2:0] REG_CLASS_MASK = 3'd5;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [63:0] ONE_Q60     = 64'sh1000_0000_0000_0000;
    localparam logic [16:0]        WEIGHT_ONE  = 17'd65536;

    localparam logic [5:0] SQRT_STEPS  = 6'd32;
    localparam logic [5:0] NORM_STEPS  = 6'd30;
    localparam logic [5:0] WEIGHT_STEPS = 6'd16;
    localparam logic [4:0] CORDIC_LAST = 5'd29;

    typedef enum logic {OP_SQRT, OP_DIV} unit_op_t;

    typedef struct packed {
        logic     go;
        unit_op_t op;
        logic [5:0] steps;
    } unit_req_t;

    // arctangent of 2^-i, Q2.30 radians
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/szpw_seq_unit.sv */
// Shared iterative unit: integer square root (two radicand bits per cycle) and
// restoring division (one quotient bit per cycle). Depends on szpw_pkg.
module szpw_seq_unit
    import szpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  unit_req_t   req,
    input  logic [63:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [31:0] result
);

    typedef enum logic {U_IDLE, U_RUN} ustate_t;

    ustate_t     state_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    unit_op_t    op_reg;
    logic [63:0] rad_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] div_reg;

    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic [32:0] dv_rem;

    always_comb
    begin
        sq_rem   = {rem_reg[33:0], rad_reg[63:62]};
        sq_trial = {2'b00, root_reg, 2'b01};
        dv_rem   = {rem_reg[31:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.go)
                    begin
                        cnt_reg   <= req.steps;
                        state_reg <= U_RUN;
                    end
                end
                U_RUN:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && req.go)
        begin
            op_reg  <= req.op;
            div_reg <= opb;
            rad_reg <= opa;
            if (req.op == OP_SQRT)
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (opa[33:0] >= {2'b00, opb})
            begin
                // head at least the divisor: leading quotient bit
                rem_reg  <= 36'(opa[33:0] - {2'b00, opb});
                root_reg <= 32'd1;
            end
            else
            begin
                rem_reg  <= 36'(opa[33:0]);
                root_reg <= '0;
            end
        end
        else if (state_reg == U_RUN)
        begin
            if (op_reg == OP_SQRT)
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (sq_rem >= sq_trial)
                begin
                    rem_reg  <= sq_rem - sq_trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_rem;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            else if (dv_rem >= {1'b0, div_reg})
            begin
                rem_reg  <= 36'(dv_rem - {1'b0, div_reg});
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 36'(dv_rem);
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = root_reg;

`ifndef SYNTHESIS
    a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == U_RUN)
        else $error("unit done without a running operation");
    a_go_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.go && state_reg == U_IDLE) |=> state_reg == U_RUN)
        else $error("unit did not start on request");
    a_nonzero_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (req.go && state_reg == U_IDLE) |-> req.steps != 6'd0)
        else $error("unit started with zero steps");
`endif

endmodule

/* hdl/spherical_zone_protection_weight_unit.sv */
// Top level of the spherical zone protection weight unit: zone memory, query
// sequencer, CORDIC and weight logic. Depends on szpw_pkg and szpw_seq_unit.
//
//  channel   signals                                  transfer when
//  --------  ---------------------------------------  ---------------------------
//  command   start, busy, mode .. feature_class       start high, busy low
//  result    done, query_valid, blocked, weight,      done high (one cycle)
//            best_entry
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready
//
// A zone write leaves the sequencer idle; its all-zero result strobes the next cycle.
// A query strobes once every zone in use has been walked: each zone walks a memory
// read, a dot product, a square root on the shared unit and the CORDIC steps, plus
// a weight divide on the shared unit if its distance falls in the blend band.
// Rejected queries strobe from the check state, with no zone walked.
// Reset clears the zone-written bits at once; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the strobe cycle.
module spherical_zone_protection_weight_unit
    import szpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [4:0]         entry_index,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic [31:0]        hard_radius,
    input  logic [31:0]        blend_radius,
    input  logic signed [39:0] point_x,
    input  logic signed [39:0] point_y,
    input  logic signed [39:0] point_z,
    input  logic [2:0]         feature_class,
    output logic               done,
    output logic               query_valid,
    output logic               blocked,
    output logic [16:0]        weight,
    output logic [4:0]         best_entry,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [39:0]        cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_MAX, S_NORM, S_SQ, S_NSQ_GO, S_NSQ_WT, S_QDV_GO, S_QDV_WT,
        S_RD, S_DOT, S_CLAMP, S_CSQ, S_SSQ_GO, S_SSQ_WT, S_CINIT, S_CORDIC, S_MUL,
        S_CMP, S_WDV_GO, S_WDV_WT, S_UPD
    } state_t;

    state_t state_reg;

    // configuration
    logic [39:0] center_x_reg, center_y_reg, center_z_reg;
    logic [31:0] radius_reg;
    logic [5:0]  entries_reg;
    logic [7:0]  class_mask_reg;

    // control
    logic [MAX_ZONES-1:0] written_reg;
    logic [1:0]           j_reg;
    logic [ZONE_AW-1:0]   k_reg;
    logic [4:0]           i_reg;
    logic [16:0]          best_reg;
    logic [ZONE_AW-1:0]   best_k_reg;
    logic                 done_reg, qvalid_reg, blocked_reg;
    logic [16:0]          weight_reg;
    logic [4:0]           best_entry_reg;

    // datapath
    logic [ENTRY_W-1:0]  zone_mem [MAX_ZONES];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic signed [40:0]  off_reg [3];
    logic [40:0]         mag_reg [3];
    logic [2:0]          neg_reg;
    logic [2:0]          cls_reg;
    logic [40:0]         mx_reg;
    logic [63:0]         ss_reg;
    logic [31:0]         norm_reg;
    logic signed [31:0]  q_reg [3];
    logic signed [63:0]  acc_reg;
    logic signed [31:0]  c_reg;
    logic [63:0]         arg_reg;
    logic [31:0]         s_reg;
    logic signed [33:0]  x_reg, y_reg, z_reg;
    logic [33:0]         d_reg;
    logic [31:0]         diff_reg;
    logic [16:0]         w_reg;

    // shared unit
    unit_req_t   u_req;
    logic [63:0] u_opa;
    logic [31:0] u_opb;
    logic        u_done;
    logic [31:0] u_result;

    szpw_seq_unit u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (u_req),
        .opa    (u_opa),
        .opb    (u_opb),
        .done   (u_done),
        .result (u_result)
    );

    // combinational helpers
    logic                accept, wr_ok, reject, zone_last;
    logic [MAX_ZONES-1:0] need_mask;
    logic [40:0]         max01, max3;
    logic [61:0]         sq_mag;
    logic signed [31:0]  dir_sel;
    logic signed [63:0]  dot_prod, dotc, negd, cval, csq;
    logic signed [33:0]  xs, ys, nx, ny, nz, atan_v;
    logic [31:0]         zpos, hard_v, blend_v;
    logic [63:0]         dprod;
    logic [33:0]         diff34;
    logic                upd_take;

    assign accept    = start && (state_reg == S_IDLE);
    assign wr_ok     = (32'(entry_index) < MAX_ZONES);
    assign zone_last = ((CNT_W'(k_reg) + CNT_W'(1)) == entries_reg);
    assign hard_v    = rd_data_reg[127:96];
    assign blend_v   = rd_data_reg[159:128];

    always_comb
    begin
        for (int m = 0; m < MAX_ZONES; m++)
        begin
            need_mask[m] = (CNT_W'(m) < entries_reg);
        end
        reject = !class_mask_reg[cls_reg] || (entries_reg == '0)
              || (entries_reg > CNT_W'(MAX_ZONES))
              || !(&(written_reg | ~need_mask))
              || ((off_reg[0] == '0) && (off_reg[1] == '0) && (off_reg[2] == '0));

        max01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max3  = (max01 > mag_reg[2]) ? max01 : mag_reg[2];

        sq_mag = mag_reg[j_reg][30:0] * mag_reg[j_reg][30:0];

        case (j_reg)
            2'd0:    dir_sel = rd_data_reg[31:0];
            2'd1:    dir_sel = rd_data_reg[63:32];
            default: dir_sel = rd_data_reg[95:64];
        endcase
        dot_prod = q_reg[j_reg] * dir_sel;

        if (acc_reg > ONE_Q60)
            dotc = ONE_Q60;
        else if (acc_reg < -ONE_Q60)
            dotc = -ONE_Q60;
        else
            dotc = acc_reg;
        negd = -dotc;
        cval = dotc[63] ? -(negd >>> 30) : (dotc >>> 30);
        csq  = c_reg * c_reg;

        // one vectoring step; rotate toward the x axis
        xs     = x_reg >>> i_reg;
        ys     = y_reg >>> i_reg;
        atan_v = 34'(atan_q30(i_reg));
        if (!y_reg[33] && (y_reg != '0))
        begin
            nx = x_reg + ys;
            ny = y_reg - xs;
            nz = z_reg + atan_v;
        end
        else
        begin
            nx = x_reg - ys;
            ny = y_reg + xs;
            nz = z_reg - atan_v;
        end

        zpos   = z_reg[33] ? 32'd0 : z_reg[31:0];
        dprod  = zpos * radius_reg;
        diff34 = d_reg - 34'(hard_v);

        upd_take = (w_reg > best_reg);
    end

    // shared unit requests
    always_comb
    begin
        u_req = '{go: 1'b0, op: OP_SQRT, steps: SQRT_STEPS};
        u_opa = ss_reg;
        u_opb = norm_reg;
        case (state_reg)
            S_NSQ_GO:
            begin
                u_req.go = 1'b1;
            end
            S_QDV_GO:
            begin
                u_req = '{go: 1'b1, op: OP_DIV, steps: NORM_STEPS};
                u_opa = 64'(mag_reg[j_reg][30:0]);
            end
            S_SSQ_GO:
            begin
                u_req.go = 1'b1;
                u_opa    = arg_reg;
            end
            S_WDV_GO:
            begin
                u_req = '{go: 1'b1, op: OP_DIV, steps: WEIGHT_STEPS};
                u_opa = 64'(diff_reg);
                u_opb = blend_v;
            end
            default: ;
        endcase
    end

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_reg     <= 32'd203718327;
            entries_reg    <= 6'd27;
            class_mask_reg <= 8'd63;
            written_reg    <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            best_reg       <= '0;
            best_k_reg     <= '0;
            done_reg       <= 1'b0;
            qvalid_reg     <= 1'b0;
            blocked_reg    <= 1'b0;
            weight_reg     <= '0;
            best_entry_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_CENTER_X:   center_x_reg   <= cfg_data;
                    REG_CENTER_Y:   center_y_reg   <= cfg_data;
                    REG_CENTER_Z:   center_z_reg   <= cfg_data;
                    REG_RADIUS:     radius_reg     <= cfg_data[31:0];
                    REG_ENTRIES:    entries_reg    <= cfg_data[5:0];
                    REG_CLASS_MASK: class_mask_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!mode)
                        begin
                            if (wr_ok)
                                written_reg[ZONE_AW'(entry_index)] <= 1'b1;
                            done_reg       <= 1'b1;
                            qvalid_reg     <= 1'b0;
                            blocked_reg    <= 1'b0;
                            weight_reg     <= '0;
                            best_entry_reg <= '0;
                        end
                        else
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (reject)
                    begin
                        done_reg       <= 1'b1;
                        qvalid_reg     <= 1'b0;
                        blocked_reg    <= 1'b0;
                        weight_reg     <= '0;
                        best_entry_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_MAX;
                end
                S_MAX:
                    state_reg <= S_NORM;
                S_NORM:
                begin
                    if ((mx_reg[40:31] == '0) && mx_reg[30])
                    begin
                        j_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd2)
                        state_reg <= S_NSQ_GO;
                end
                S_NSQ_GO:
                    state_reg <= S_NSQ_WT;
                S_NSQ_WT:
                begin
                    if (u_done)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_QDV_GO;
                    end
                end
                S_QDV_GO:
                    state_reg <= S_QDV_WT;
                S_QDV_WT:
                begin
                    if (u_done)
                    begin
                        if (j_reg == 2'd2)
                        begin
                            k_reg      <= '0;
                            best_reg   <= '0;
                            best_k_reg <= '0;
                            state_reg  <= S_RD;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_QDV_GO;
                        end
                    end
                end
                S_RD:
                begin
                    j_reg     <= '0;
                    state_reg <= S_DOT;
                end
                S_DOT:
                begin
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd2)
                        state_reg <= S_CLAMP;
                end
                S_CLAMP:
                    state_reg <= S_CSQ;
                S_CSQ:
                    state_reg <= S_SSQ_GO;
                S_SSQ_GO:
                    state_reg <= S_SSQ_WT;
                S_SSQ_WT:
                begin
                    if (u_done)
                        state_reg <= S_CINIT;
                end
                S_CINIT:
                begin
                    i_reg     <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == CORDIC_LAST)
                        state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if ((d_reg <= 34'(hard_v)) || (blend_v == '0)
                        || (d_reg >= (34'(hard_v) + 34'(blend_v))))
                        state_reg <= S_UPD;
                    else
                        state_reg <= S_WDV_GO;
                end
                S_WDV_GO:
                    state_reg <= S_WDV_WT;
                S_WDV_WT:
                begin
                    if (u_done)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (upd_take)
                    begin
                        best_reg   <= w_reg;
                        best_k_reg <= k_reg;
                    end
                    if (zone_last)
                    begin
                        done_reg       <= 1'b1;
                        qvalid_reg     <= 1'b1;
                        weight_reg     <= upd_take ? w_reg : best_reg;
                        blocked_reg    <= upd_take ? (w_reg != '0) : (best_reg != '0);
                        best_entry_reg <= 5'(upd_take ? k_reg : best_k_reg);
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + ZONE_AW'(1);
                        state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // zone memory and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && !mode && wr_ok)
            zone_mem[ZONE_AW'(entry_index)] <= {blend_radius, hard_radius, dir_z, dir_y, dir_x};
        if (state_reg == S_RD)
            rd_data_reg <= zone_mem[k_reg];

        case (state_reg)
            S_IDLE:
            begin
                cls_reg    <= feature_class;
                off_reg[0] <= {point_x[39], point_x} - {center_x_reg[39], center_x_reg};
                off_reg[1] <= {point_y[39], point_y} - {center_y_reg[39], center_y_reg};
                off_reg[2] <= {point_z[39], point_z} - {center_z_reg[39], center_z_reg};
            end
            S_CHECK:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    neg_reg[a] <= off_reg[a][40];
                    mag_reg[a] <= off_reg[a][40] ? 41'(-off_reg[a]) : 41'(off_reg[a]);
                end
            end
            S_MAX:
            begin
                mx_reg <= max3;
                ss_reg <= '0;
            end
            S_NORM:
            begin
                // bring the largest magnitude into [2^30, 2^31)
                if (mx_reg[40:31] != '0)
                begin
                    mx_reg <= mx_reg >> 1;
                    for (int a = 0; a < 3; a++)
                        mag_reg[a] <= mag_reg[a] >> 1;
                end
                else if (!mx_reg[30])
                begin
                    mx_reg <= mx_reg << 1;
                    for (int a = 0; a < 3; a++)
                        mag_reg[a] <= mag_reg[a] << 1;
                end
            end
            S_SQ:
                ss_reg <= ss_reg + 64'(sq_mag);
            S_NSQ_WT:
            begin
                if (u_done)
                    norm_reg <= u_result;
            end
            S_QDV_WT:
            begin
                if (u_done)
                    q_reg[j_reg] <= neg_reg[j_reg] ? -u_result : u_result;
            end
            S_RD:
                acc_reg <= '0;
            S_DOT:
                acc_reg <= acc_reg + dot_prod;
            S_CLAMP:
                c_reg <= cval[31:0];
            S_CSQ:
                arg_reg <= 64'(ONE_Q60 - csq);
            S_SSQ_WT:
            begin
                if (u_done)
                    s_reg <= u_result;
            end
            S_CINIT:
            begin
                if (!c_reg[31])
                begin
                    x_reg <= 34'(c_reg);
                    y_reg <= {2'b00, s_reg};
                    z_reg <= '0;
                end
                else
                begin
                    x_reg <= {2'b00, s_reg};
                    y_reg <= -34'(c_reg);
                    z_reg <= HALF_PI_Q30;
                end
            end
            S_CORDIC:
            begin
                x_reg <= nx;
                y_reg <= ny;
                z_reg <= nz;
            end
            S_MUL:
                d_reg <= dprod[63:30];
            S_CMP:
            begin
                diff_reg <= diff34[31:0];
                if (d_reg <= 34'(hard_v))
                    w_reg <= WEIGHT_ONE;
                else
                    w_reg <= '0;
            end
            S_WDV_WT:
            begin
                if (u_done)
                    w_reg <= WEIGHT_ONE - {1'b0, u_result[15:0]};
            end
            default: ;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign query_valid = qvalid_reg;
    assign blocked     = blocked_reg;
    assign weight      = weight_reg;
    assign best_entry  = best_entry_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !query_valid) |-> (weight == '0 && !blocked && best_entry == '0))
        else $error("rejected transfer carries a nonzero result");
    a_blocked_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && query_valid) |-> (blocked == (weight != '0)) && (weight <= WEIGHT_ONE))
        else $error("blocked flag or weight range mismatch");
    a_unit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (state_reg == S_NSQ_WT || state_reg == S_QDV_WT
                    || state_reg == S_SSQ_WT || state_reg == S_WDV_WT))
        else $error("shared unit finished outside a wait state");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode) |=> busy)
        else $error("query accepted but sequencer idle");
`endif

endmodule

/* sim/spherical_zone_protection_weight_unit_tb.sv */
// Self-checking testbench of spherical_zone_protection_weight_unit: a stimulus table,
// then random zone writes, queries and register phases. Depends on szpw_pkg and the RTL.
module spherical_zone_protection_weight_unit_tb;
    import szpw_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint UNIT_Q60    = longint'(1) << 60;
    localparam longint QUARTER_PI2 = 1686629713;    // pi/2 in Q2.30

    // arctangent of 2^-i in Q2.30 radians for the vectoring loop
    localparam longint ATAN_STEP [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    typedef struct {
        logic               mode;
        logic [4:0]         idx;
        logic signed [31:0] dx, dy, dz;
        logic [31:0]        hr, br;
        logic signed [39:0] px, py, pz;
        logic [2:0]         cls;
    } zone_cmd_t;

    typedef struct {
        logic        qv;
        logic        blk;
        logic [16:0] wt;
        logic [4:0]  be;
    } zone_result_t;

    typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [2:0] reg_idx;
        logic [39:0] reg_val;
        zone_cmd_t  cmd;
        bit         zero_exp;   // result typed in: all fields zero
    } stim_row_t;

    // ---------------------------------------------------------------- DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               mode = 1'b0;
    logic [4:0]         entry_index = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [31:0]        hard_radius = '0, blend_radius = '0;
    logic signed [39:0] point_x = '0, point_y = '0, point_z = '0;
    logic [2:0]         feature_class = '0;
    logic               done;
    logic               query_valid;
    logic               blocked;
    logic [16:0]        weight;
    logic [4:0]         best_entry;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [39:0]        cfg_data = '0;

    spherical_zone_protection_weight_unit DUT (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------ predictor state
    logic signed [39:0] sph_cx, sph_cy, sph_cz;
    logic [31:0]        sph_radius;
    logic [5:0]         sph_entries;
    logic [7:0]         sph_mask;
    logic signed [31:0] tab_dx [MAX_ZONES];
    logic signed [31:0] tab_dy [MAX_ZONES];
    logic signed [31:0] tab_dz [MAX_ZONES];
    logic [31:0]        tab_hard [MAX_ZONES];
    logic [31:0]        tab_blend [MAX_ZONES];
    bit                 tab_written [MAX_ZONES];

    zone_result_t pending_results [$];
    int  mismatches = 0;
    int  n_writes = 0, n_evaluated = 0, n_rejected = 0, n_blocked = 0;
    bit  no_idle = 1'b0;
    longint cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = longint'(1) << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // weight of one zone for a Q1.30 unit direction q
    function automatic longint unsigned zone_weight_of(longint q0, longint q1, longint q2,
                                                       int k);
        longint dot, c, x, y, z, nx, ny;
        longint unsigned s, d, hard, blend, zu;
        dot = q0 * longint'(tab_dx[k]) + q1 * longint'(tab_dy[k]) + q2 * longint'(tab_dz[k]);
        if (dot > UNIT_Q60) dot = UNIT_Q60;
        if (dot < -UNIT_Q60) dot = -UNIT_Q60;
        c = (dot >= 0) ? (dot >>> 30) : -((-dot) >>> 30);
        s = int_sqrt(longint'(UNIT_Q60 - c * c));
        if (c >= 0) begin
            x = c; y = s; z = 0;
        end else begin
            // start a quarter turn on so the loop stays in its range
            x = s; y = -c; z = QUARTER_PI2;
        end
        for (int i = 0; i < 30; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_STEP[i];
            end
            x = nx; y = ny;
        end
        if (z < 0) z = 0;
        zu = z;
        d = (zu * {32'd0, sph_radius}) >> 30;
        hard = {32'd0, tab_hard[k]};
        blend = {32'd0, tab_blend[k]};
        if (d <= hard) return 65536;
        if (blend == 0 || d >= hard + blend) return 0;
        return 65536 - (((d - hard) << 16) / blend);
    endfunction

    // expected result of one command; a write also updates the zone table
    function automatic zone_result_t predict_zone_cmd(zone_cmd_t c);
        zone_result_t r;
        longint off [3];
        longint q [3];
        longint unsigned mag [3];
        longint unsigned mx, ss, norm, best, w;
        int len, best_k;
        r = '{1'b0, 1'b0, 17'd0, 5'd0};
        if (c.mode == 1'b0) begin
            tab_dx[c.idx] = c.dx; tab_dy[c.idx] = c.dy; tab_dz[c.idx] = c.dz;
            tab_hard[c.idx] = c.hr; tab_blend[c.idx] = c.br;
            tab_written[c.idx] = 1'b1;
            n_writes++;
            return r;
        end
        if (!sph_mask[c.cls] || sph_entries == 0 || sph_entries > MAX_ZONES) begin
            n_rejected++;
            return r;
        end
        for (int i = 0; i < sph_entries; i++)
            if (!tab_written[i]) begin
                n_rejected++;
                return r;
            end
        off[0] = longint'(c.px) - longint'(sph_cx);
        off[1] = longint'(c.py) - longint'(sph_cy);
        off[2] = longint'(c.pz) - longint'(sph_cz);
        if (off[0] == 0 && off[1] == 0 && off[2] == 0) begin
            n_rejected++;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (off[i] < 0) ? -off[i] : off[i];
            if (mag[i] > mx) mx = mag[i];
        end
        len = 0;
        while (mx != 0) begin
            len++;
            mx >>= 1;
        end
        ss = 0;
        for (int i = 0; i < 3; i++) begin
            if (len > 31) mag[i] >>= (len - 31);
            else mag[i] <<= (31 - len);
            ss += mag[i] * mag[i];
        end
        norm = int_sqrt(ss);
        for (int i = 0; i < 3; i++)
            q[i] = (off[i] < 0) ? -longint'((mag[i] << 30) / norm)
                                : longint'((mag[i] << 30) / norm);
        best = 0;
        best_k = 0;
        for (int i = 0; i < sph_entries; i++) begin
            w = zone_weight_of(q[0], q[1], q[2], i);
            if (w > best) begin
                best = w;
                best_k = i;
            end
        end
        r.qv = 1'b1;
        r.blk = (best > 0);
        r.wt = best[16:0];
        r.be = best_k[4:0];
        n_evaluated++;
        if (best > 0) n_blocked++;
        return r;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [39:0] val);
        case (idx)
            REG_CENTER_X:   sph_cx = val;
            REG_CENTER_Y:   sph_cy = val;
            REG_CENTER_Z:   sph_cz = val;
            REG_RADIUS:     sph_radius = val[31:0];
            REG_ENTRIES:    sph_entries = val[5:0];
            REG_CLASS_MASK: sph_mask = val[7:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------- result checker
    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH @%0d %s: got %0d, want %0d", cycles, field, got, want);
        mismatches++;
    endtask

    // results cannot be held off: every strobe is a transfer
    always @(posedge clk) begin
        zone_result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end else if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (query_valid !== e.qv) report_mismatch("query_valid", query_valid, e.qv);
                if (blocked !== e.blk) report_mismatch("blocked", blocked, e.blk);
                if (weight !== e.wt) report_mismatch("weight", weight, e.wt);
                if (best_entry !== e.be) report_mismatch("best_entry", best_entry, e.be);
            end
        end
    end

    // ------------------------------------------------------------- drivers
    task automatic idle_gap();
        if (!no_idle)
            while ($urandom_range(99) < 30) begin
                start <= 1'b0;
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
    endtask

    // one command transfer; the expectation is queued at the accepting edge
    task automatic send_cmd(zone_cmd_t c, bit zero_exp);
        zone_result_t r;
        idle_gap();
        start <= 1'b1;
        cfg_valid <= 1'b0;
        mode <= c.mode;
        entry_index <= c.idx;
        dir_x <= c.dx; dir_y <= c.dy; dir_z <= c.dz;
        hard_radius <= c.hr; blend_radius <= c.br;
        point_x <= c.px; point_y <= c.py; point_z <= c.pz;
        feature_class <= c.cls;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = predict_zone_cmd(c);
        if (zero_exp) r = '{1'b0, 1'b0, 17'd0, 5'd0};
        pending_results.push_back(r);
    endtask

    // every result has arrived and the block has gone quiet
    task automatic wait_idle();
        start <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy) @(posedge clk);
    endtask

    // valid stays up for a following write; the next command or wait drops it
    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        idle_gap();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_reg(idx, val);
    endtask

    // ------------------------------------------------------ stimulus helpers
    stim_row_t stim_rows [$];

    function automatic zone_cmd_t mk_write(logic [4:0] idx, longint dx, longint dy, longint dz,
                                           logic [31:0] hr, logic [31:0] br);
        zone_cmd_t c;
        c = '{1'b0, idx, dx, dy, dz, hr, br, 40'sd0, 40'sd0, 40'sd0, 3'd0};
        return c;
    endfunction

    function automatic zone_cmd_t mk_query(longint px, longint py, longint pz, logic [2:0] cls);
        zone_cmd_t c;
        c = '{1'b1, 5'd0, 32'sd0, 32'sd0, 32'sd0, 32'd0, 32'd0, px, py, pz, cls};
        return c;
    endfunction

    function automatic void add_cmd(zone_cmd_t c, bit zero_exp);
        stim_rows.push_back('{ROW_CMD, 3'd0, 40'd0, c, zero_exp});
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [39:0] val);
        stim_rows.push_back('{ROW_CFG, idx, val, mk_query(0, 0, 0, 0), 1'b0});
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(3))
            0: return ($urandom_range(1)) ? 32'sh4000_0000 : -32'sh4000_0000;
            1: return 32'sd0;
            default: return longint'($urandom_range(32'h8000_0000, 0)) - (longint'(1) << 30);
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(sph_radius, 0);
        endcase
    endfunction

    function automatic logic [39:0] rand40();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[39:0];
    endfunction

    // query point near one written zone, on the centre, or anywhere
    function automatic zone_cmd_t rand_query();
        int k, sh;
        longint scale;
        logic [39:0] px, py, pz;
        k = $urandom_range(31);
        if ($urandom_range(3) != 0 && tab_written[k]) begin
            sh = $urandom_range(24);
            scale = longint'(1) << $urandom_range(8);
            px = sph_cx + ((longint'(tab_dx[k]) * scale) >>> sh) + $signed($urandom_range(64)) - 32;
            py = sph_cy + ((longint'(tab_dy[k]) * scale) >>> sh) + $signed($urandom_range(64)) - 32;
            pz = sph_cz + ((longint'(tab_dz[k]) * scale) >>> sh) + $signed($urandom_range(64)) - 32;
        end else if ($urandom_range(15) == 0) begin
            px = sph_cx; py = sph_cy; pz = sph_cz;   // zero offset
        end else begin
            px = rand40(); py = rand40(); pz = rand40();
        end
        return mk_query(longint'($signed(px)), longint'($signed(py)), longint'($signed(pz)),
                        $urandom_range(7));
    endfunction

    function automatic logic [39:0] rand_center();
        case ($urandom_range(3))
            0: return 40'd0;
            1: return ($urandom_range(1)) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
            default: return rand40();
        endcase
    endfunction

    // --------------------------------------------------------------- main
    initial begin
        int n, idx;
        zone_cmd_t c;
        sph_cx = '0; sph_cy = '0; sph_cz = '0;
        sph_radius = 32'd203718327;
        sph_entries = 6'd27;
        sph_mask = 8'd63;
        foreach (tab_written[i]) tab_written[i] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: after reset, extremes and the table, class and centre rejections
        add_cmd(mk_query(1, 0, 0, 0), 1'b1);                   // table incomplete at reset
        add_reg(REG_ENTRIES, 40'd1);
        add_cmd(mk_write(0, 1 << 30, 0, 0, 0, 0), 1'b1);
        add_cmd(mk_query(5, 0, 0, 0), 1'b0);                   // dead on zone 0
        add_cmd(mk_query(0, 5, 0, 0), 1'b0);                   // a quarter turn off
        add_cmd(mk_query(-5, 0, 0, 0), 1'b0);                  // antipode
        add_cmd(mk_query(5, 0, 0, 6), 1'b1);                   // unprotected class
        add_cmd(mk_query(0, 0, 0, 0), 1'b1);                   // point on the centre
        add_cmd(mk_write(31, -(1 << 30), -(1 << 30), -(1 << 30), 32'hFFFF_FFFF,
                         32'hFFFF_FFFF), 1'b1);
        add_reg(REG_ENTRIES, 40'd32);
        add_cmd(mk_query(5, 0, 0, 0), 1'b1);                   // slots 1..30 unwritten
        add_reg(REG_ENTRIES, 40'd2);
        add_cmd(mk_write(1, 0, -(1 << 30), 0, 1000, 0), 1'b1);
        add_cmd(mk_query(-(longint'(1) << 39), -(longint'(1) << 39), -(longint'(1) << 39), 3),
                1'b0);
        add_cmd(mk_query((longint'(1) << 39) - 1, (longint'(1) << 39) - 1, 1, 5), 1'b0);
        add_cmd(mk_write(1, 1 << 30, 0, 0, 0, 32'd100000000), 1'b1);   // tie with zone 0
        add_cmd(mk_query(3, 4, 0, 0), 1'b0);
        add_reg(REG_CLASS_MASK, 40'd255);
        add_reg(REG_RADIUS, 40'd1);
        add_reg(REG_CENTER_X, 40'h7F_FFFF_FFFF);
        add_reg(REG_CENTER_Y, 40'h80_0000_0000);
        add_reg(REG_CENTER_Z, 40'd0);
        add_cmd(mk_query(-(longint'(1) << 39), (longint'(1) << 39) - 1, 7, 7), 1'b0);
        add_reg(REG_RADIUS, 40'hFF_FFFF_FFFF);
        add_cmd(mk_query(0, 0, -9, 7), 1'b0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end else begin
                send_cmd(stim_rows[i].cmd, stim_rows[i].zero_exp);
            end
        end

        // random phases: every register rewritten while idle, then the table is filled
        // in order (slots may be skipped from phase 2 on) and queried, with stray writes in between
        for (int ph = 0; ph < 14; ph++) begin
            wait_idle();
            no_idle = (ph == 5 || ph == 6);
            write_reg(REG_CENTER_X, rand_center());
            write_reg(REG_CENTER_Y, rand_center());
            write_reg(REG_CENTER_Z, rand_center());
            case (ph % 4)
                0: write_reg(REG_RADIUS, 40'd1);
                1: write_reg(REG_RADIUS, 40'hFFFF_FFFF);
                default: write_reg(REG_RADIUS, $urandom_range(32'd400000000, 1));
            endcase
            n = (ph == 3) ? 32 : $urandom_range(4, 1);
            write_reg(REG_ENTRIES, n);
            case (ph % 5)
                0: write_reg(REG_CLASS_MASK, 40'd255);
                1: write_reg(REG_CLASS_MASK, 40'd0);
                default: write_reg(REG_CLASS_MASK, $urandom_range(255));
            endcase
            for (int k = 0; k < n; k++)
                if ($urandom_range(7) != 0 || ph < 2)
                    send_cmd(mk_write(k, rand_dir(), rand_dir(), rand_dir(), rand_len(),
                                      rand_len()), 1'b0);
            for (int it = 0; it < ((n == 32) ? 8 : 34); it++) begin
                if ($urandom_range(99) < 65) begin
                    send_cmd(rand_query(), 1'b0);
                end else begin
                    idx = (n == 32) ? $urandom_range(31) : $urandom_range(31);
                    c = mk_write(idx, rand_dir(), rand_dir(), rand_dir(), rand_len(), rand_len());
                    send_cmd(c, 1'b0);
                end
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d zone writes, %0d evaluated queries (%0d blocked), %0d rejected",
                 n_writes, n_evaluated, n_blocked, n_rejected);
        $display("over 14 register phases with table sizes from 1 to 32 zones");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/szpw_pkg.sv
hdl/szpw_seq_unit.sv
hdl/spherical_zone_protection_weight_unit.sv
sim/spherical_zone_protection_weight_unit_tb.sv
